FILE: sv/slxd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync/length/XOR deframer package
// Shared widths, reset values, register indexes, status codes and the
// result record of the deframer.
// ----------------------------------------------------------------------------
package slxd_pkg;

    // Field widths of the streams and the configuration port.
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    // Output data: payload byte, type, payload length, status, padded to bytes.
    localparam int M_FIELDS_W = BYTE_W + BYTE_W + LEN_W + STATUS_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SCAN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TRANSFORM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CLOUD     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PARAM     = 3'd5;

    // Register reset values.
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST    = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST   = 8'h55;
    localparam logic [LEN_W-1:0]  MIN_SCAN_RST      = 16'd28;
    localparam logic [LEN_W-1:0]  MIN_TRANSFORM_RST = 16'd64;
    localparam logic [LEN_W-1:0]  MIN_CLOUD_RST     = 16'd16;
    localparam logic [LEN_W-1:0]  MIN_PARAM_RST     = 16'd4;

    // Message type codes.
    localparam logic [BYTE_W-1:0] TYPE_SCAN      = 8'd1;
    localparam logic [BYTE_W-1:0] TYPE_TRANSFORM = 8'd2;
    localparam logic [BYTE_W-1:0] TYPE_CLOUD     = 8'd3;
    localparam logic [BYTE_W-1:0] TYPE_PARAM     = 8'd4;

    // Frame layout: sync(2) + length(2) + type(1) + checksum(1).
    localparam logic [LEN_W-1:0] HEADER_LEN   = 16'd4;
    localparam logic [LEN_W-1:0] OVERHEAD_LEN = 16'd6;
    localparam logic [LEN_W-1:0] TYPE_POS     = 16'd4;
    localparam logic [LEN_W-1:0] SYNC_DONE_POS = 16'd2;
    localparam logic [LEN_W-1:0] LENHI_DONE_POS = 16'd3;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // End-of-frame verdicts.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_BADSUM   = 3'd2,
        ST_BADTYPE  = 3'd3,
        ST_PAYSHORT = 3'd4
    } status_t;

    // One result item.
    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] message_type;
        logic [LEN_W-1:0]  payload_length;
        status_t           status;
    } result_t;

endpackage

FILE: sv/sync_length_xor_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync/length/XOR deframer
// Hunts for a two-byte sync word, reads a big-endian frame length, forwards
// payload bytes and gives one checksum/type/length verdict per frame.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one received byte per transaction (s_tdata[7:0]).
//   m_* carries results: m_tuser = 0 for a forwarded payload byte, 1 for an
//   end-of-frame verdict; m_tdata holds byte, type, payload length, status.
//   cfg_* writes the sync bytes and the per-type minimum payload sizes; it
//   is always ready and should be used only while the stream is idle.
// Throughput and results:
//   One byte is accepted per cycle while the skid register is empty. Its state
//   update is registered on acceptance; its result goes to the output register,
//   or to the skid register while the output is held. Bytes with no result
//   (header bytes, the type byte, hunting) leave the output side untouched.
// Reset and stalls:
//   aresetn (synchronous, active low) restores the register defaults, sends
//   the parser back to hunting and drops any pending result.
//   An output register plus a one-entry skid register decouple the sides: a
//   byte is still accepted while one result waits on a stalled receiver; the
//   input stalls only when both entries hold results.
// ----------------------------------------------------------------------------
module sync_length_xor_deframer_unit
    import slxd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,      // [7:0] rx_byte
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,      // [7:0] payload_byte,
                                                // [15:8] message_type,
                                                // [31:16] payload_length,
                                                // [34:32] frame_status, rest 0
    output logic                  m_tuser,      // [0] result_kind
    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_LENHI = 3'd2,
        PH_LENLO = 3'd3,
        PH_BODY  = 3'd4
    } phase_t;

    // Configuration registers
    logic [BYTE_W-1:0] sync_first_reg;
    logic [BYTE_W-1:0] sync_second_reg;
    logic [LEN_W-1:0]  min_scan_reg;
    logic [LEN_W-1:0]  min_transform_reg;
    logic [LEN_W-1:0]  min_cloud_reg;
    logic [LEN_W-1:0]  min_param_reg;

    // Parser state
    phase_t            phase_reg,  phase_next;
    logic [LEN_W-1:0]  pos_reg,    pos_next;
    logic [LEN_W-1:0]  len_reg,    len_next;
    logic [BYTE_W-1:0] xor_reg,    xor_next;
    logic [BYTE_W-1:0] type_reg,   type_next;

    // Output register and skid register
    logic              m_valid_reg;
    result_t           m_res_reg;
    logic              skid_valid_reg;
    result_t           skid_res_reg;

    logic              s_accept;
    logic              out_free;
    logic              res_valid;
    result_t           res;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    // Configuration writes; unused indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg    <= SYNC_FIRST_RST;
            sync_second_reg   <= SYNC_SECOND_RST;
            min_scan_reg      <= MIN_SCAN_RST;
            min_transform_reg <= MIN_TRANSFORM_RST;
            min_cloud_reg     <= MIN_CLOUD_RST;
            min_param_reg     <= MIN_PARAM_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SYNC_FIRST:    sync_first_reg    <= cfg_data[BYTE_W-1:0];
                CFG_SYNC_SECOND:   sync_second_reg   <= cfg_data[BYTE_W-1:0];
                CFG_MIN_SCAN:      min_scan_reg      <= cfg_data[LEN_W-1:0];
                CFG_MIN_TRANSFORM: min_transform_reg <= cfg_data[LEN_W-1:0];
                CFG_MIN_CLOUD:     min_cloud_reg     <= cfg_data[LEN_W-1:0];
                CFG_MIN_PARAM:     min_param_reg     <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Parser step for one received byte.
    always_comb begin
        logic [BYTE_W-1:0]  b;
        logic [LEN_W-1:0]   len_full;
        logic               is_last;
        logic [BYTE_W-1:0]  type_eff;
        logic [LEN_W-1:0]   pay_len;
        logic [LEN_W-1:0]   need;
        logic               type_known;

        b        = s_tdata;
        len_full = {len_reg[LEN_W-1:BYTE_W], b};
        is_last  = ({1'b0, pos_reg} + {{LEN_W{1'b0}}, 1'b1}) >= {1'b0, len_reg};
        type_eff = (pos_reg == TYPE_POS) ? b : type_reg;
        pay_len  = (len_reg >= OVERHEAD_LEN) ? (len_reg - OVERHEAD_LEN) : '0;

        // Minimum payload for the frame's type.
        type_known = 1'b1;
        priority if (type_eff == TYPE_SCAN) begin
            need = min_scan_reg;
        end else if (type_eff == TYPE_TRANSFORM) begin
            need = min_transform_reg;
        end else if (type_eff == TYPE_CLOUD) begin
            need = min_cloud_reg;
        end else if (type_eff == TYPE_PARAM) begin
            need = min_param_reg;
        end else begin
            need       = '0;
            type_known = 1'b0;
        end

        phase_next = phase_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        xor_next   = xor_reg;
        type_next  = type_reg;
        res_valid  = 1'b0;
        res        = '{kind: KIND_PAYLOAD, payload_byte: '0, message_type: '0,
                       payload_length: '0, status: ST_OK};

        unique case (phase_reg)
            PH_HUNT1: begin
                if (b == sync_first_reg) begin
                    phase_next = PH_HUNT2;
                end
            end
            PH_HUNT2: begin
                // The second sync byte is tested first; a repeated first
                // sync byte keeps waiting.
                if (b == sync_second_reg) begin
                    phase_next = PH_LENHI;
                    pos_next   = SYNC_DONE_POS;
                    len_next   = '0;
                    xor_next   = sync_first_reg ^ sync_second_reg;
                    type_next  = '0;
                end else if (b != sync_first_reg) begin
                    phase_next = PH_HUNT1;
                end
            end
            PH_LENHI: begin
                len_next   = {b, {BYTE_W{1'b0}}};
                xor_next   = xor_reg ^ b;
                pos_next   = LENHI_DONE_POS;
                phase_next = PH_LENLO;
            end
            PH_LENLO: begin
                if (len_full < HEADER_LEN) begin
                    // Drop the header and rescan the two length bytes.
                    if (len_reg[LEN_W-1:BYTE_W] == sync_first_reg &&
                        b == sync_second_reg) begin
                        phase_next = PH_LENHI;
                        pos_next   = SYNC_DONE_POS;
                        len_next   = '0;
                        xor_next   = sync_first_reg ^ sync_second_reg;
                        type_next  = '0;
                    end else begin
                        len_next   = '0;
                        pos_next   = '0;
                        xor_next   = '0;
                        phase_next = (b == sync_first_reg) ? PH_HUNT2 : PH_HUNT1;
                    end
                end else begin
                    len_next = len_full;
                    xor_next = xor_reg ^ b;
                    pos_next = HEADER_LEN;
                    if (len_full == HEADER_LEN) begin
                        // The frame ends at the length byte itself.
                        res_valid          = 1'b1;
                        res.kind           = KIND_VERDICT;
                        res.message_type   = type_reg;
                        res.status         = ST_SHORT;
                        phase_next         = PH_HUNT1;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                if (is_last) begin
                    // Last byte is the checksum: give the verdict.
                    type_next            = type_eff;
                    res_valid            = 1'b1;
                    res.kind             = KIND_VERDICT;
                    res.message_type     = type_eff;
                    res.payload_length   = pay_len;
                    priority if (len_reg < OVERHEAD_LEN) begin
                        res.status = ST_SHORT;
                    end else if (xor_reg != b) begin
                        res.status = ST_BADSUM;
                    end else if (!type_known) begin
                        res.status = ST_BADTYPE;
                    end else if (pay_len < need) begin
                        res.status = ST_PAYSHORT;
                    end else begin
                        res.status = ST_OK;
                    end
                    phase_next = PH_HUNT1;
                    pos_next   = '0;
                end else begin
                    xor_next  = xor_reg ^ b;
                    pos_next  = pos_reg + LEN_W'(1);
                    type_next = type_eff;
                    if (pos_reg != TYPE_POS) begin
                        res_valid          = 1'b1;
                        res.kind           = KIND_PAYLOAD;
                        res.payload_byte   = b;
                        res.message_type   = type_reg;
                        res.payload_length = pay_len;
                    end
                end
            end
            default: begin
                phase_next = PH_HUNT1;
            end
        endcase
    end

    // Parser state registers, advanced on each accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT1;
            pos_reg   <= '0;
            len_reg   <= '0;
            xor_reg   <= '0;
            type_reg  <= '0;
        end else if (s_accept) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            xor_reg   <= xor_next;
            type_reg  <= type_next;
        end
    end

    // Output register with skid entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= s_accept && res_valid;
            end
        end else if (s_accept && res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Result payloads follow the valid bits above.
    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                m_res_reg <= skid_res_reg;
            end else if (s_accept && res_valid) begin
                m_res_reg <= res;
            end
        end else if (s_accept && res_valid) begin
            skid_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.kind;
    assign m_tdata  = {{(M_TDATA_W - M_FIELDS_W){1'b0}},
                       m_res_reg.status,
                       m_res_reg.payload_length,
                       m_res_reg.message_type,
                       m_res_reg.payload_byte};

`ifndef SYNTH
    // The skid entry only fills behind a held output result.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry valid without output result");

    // Forwarded payload bytes always carry an ok status.
    a_payload_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_res_reg.kind == KIND_PAYLOAD) |-> m_res_reg.status == ST_OK)
        else $error("payload byte with nonzero status");

    // Inside a frame body the position stays past the header and short of the end.
    a_body_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY) |-> (pos_reg >= HEADER_LEN && pos_reg < len_reg))
        else $error("frame body position out of range");
`endif

endmodule
